/* rtl/rrt_pkg.sv */
`timescale 1ns / 1ps
package rrt_pkg;
    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_ADDED   = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_GOAL    = 3'd3,
        ST_DONE    = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CFG_START_ROW = 3'd0,
        CFG_START_COL = 3'd1,
        CFG_GOAL_ROW  = 3'd2,
        CFG_GOAL_COL  = 3'd3,
        CFG_LIMIT     = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_STEER,
        S_OUT
    } state_t;

    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
endpackage

/* rtl/rrt_if.sv */
`timescale 1ns / 1ps
interface rrt_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  map_row;
    logic [15:0] map_bits;
    logic [3:0]  sample_row;
    logic [3:0]  sample_col;
    modport source (output valid, action, map_row, map_bits, sample_row, sample_col,
                    input ready);
    modport sink (input valid, action, map_row, map_bits, sample_row, sample_col,
                  output ready);
endinterface

interface rrt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] node_row;
    logic [3:0] node_col;
    logic [7:0] node_slot;
    logic [7:0] parent_slot;
    logic       finished;
    modport source (output valid, status, node_row, node_col, node_slot, parent_slot,
                    finished, input ready);
    modport sink (input valid, status, node_row, node_col, node_slot, parent_slot,
                  finished, output ready);
endinterface

/* rtl/rrt_grid_tree_grow.sv */
`timescale 1ns / 1ps
// Grid RRT grower. For a row-load item, the block takes it and its result
// sits in the output register the next cycle. A sample item scans the node
// table through a single distance/compare unit. For each stored node, the
// S_WAIT state reads the node memory through its one registered read port
// and the S_SCAN state compares. The S_STEER state then steers and checks
// the new cell. The block takes one item at a time. The input is ready only
// in idle while no result waits. Node 0 always follows the start registers.
// Every other node memory entry is written before it is read, so the memory
// has no clearing pass.
module rrt_grid_tree_grow #(
    parameter int GRID_ROWS  = 16,
    parameter int GRID_COLS  = 16,
    parameter int NODE_SLOTS = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [rrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrt_pkg::CFG_W-1:0]     cfg_data,
    rrt_in_if.sink                   in_ch,
    rrt_out_if.source                out_ch
);
    localparam int SW = $clog2(NODE_SLOTS);
    localparam int CW = SW + 1;

    logic [3:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
    logic [15:0] limit_reg;
    logic [15:0] grid_reg [GRID_ROWS];
    logic [7:0] coord_mem [NODE_SLOTS];
    logic [7:0] parent_mem [NODE_SLOTS];
    logic [7:0] rd_coord_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0] acc_reg, acc_next;
    logic done_reg, done_next;

    rrt_pkg::state_t state_reg, state_next;
    logic [3:0] sr_reg, sc_reg;
    logic [CW-1:0] idx_reg, idx_next;  // slot currently in the read register
    logic [CW-1:0] rd_idx;
    logic [8:0] bestd_reg, bestd_next;
    logic [SW-1:0] best_reg, best_next;
    logic [7:0] bestc_reg, bestc_next;

    logic ov_reg;
    logic [2:0] ost_reg;
    logic [3:0] onr_reg, onc_reg;
    logic [7:0] ons_reg, ops_reg;
    logic ofin_reg;

    logic wr_en;
    logic [SW-1:0] wr_addr;
    logic [7:0] wr_coord, wr_par;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= 4'd1;
            start_col_reg <= 4'd1;
            goal_row_reg  <= 4'd8;
            goal_col_reg  <= 4'd10;
            limit_reg     <= 16'd10100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrt_pkg::CFG_START_ROW: start_row_reg <= cfg_data[3:0];
                rrt_pkg::CFG_START_COL: start_col_reg <= cfg_data[3:0];
                rrt_pkg::CFG_GOAL_ROW:  goal_row_reg  <= cfg_data[3:0];
                rrt_pkg::CFG_GOAL_COL:  goal_col_reg  <= cfg_data[3:0];
                rrt_pkg::CFG_LIMIT:     limit_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic in_acc, out_acc;
    assign in_ch.ready = (state_reg == rrt_pkg::S_IDLE) && !ov_reg;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = ov_reg && out_ch.ready;

    // occupancy grid: reset to free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                grid_reg[r] <= '0;
        end
        else if (in_acc && !in_ch.action && (32'(in_ch.map_row) < GRID_ROWS))
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                if (32'(in_ch.map_row) == r)
                    grid_reg[r] <= in_ch.map_bits & 16'((32'd1 << GRID_COLS) - 1);
        end
    end

    // node memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coord_mem[wr_addr]  <= wr_coord;
            parent_mem[wr_addr] <= wr_par;
        end
        rd_coord_reg <= coord_mem[rd_idx[SW-1:0]];
    end

    // distance unit for the node in the read register
    logic [3:0] cr, cc;
    logic signed [4:0] da, db;
    logic [8:0] sq_dist;
    logic [CW-1:0] cur_idx;
    assign cur_idx = idx_reg;
    assign cr = (cur_idx == '0) ? start_row_reg : rd_coord_reg[7:4];
    assign cc = (cur_idx == '0) ? start_col_reg : rd_coord_reg[3:0];
    assign da = $signed({1'b0, sr_reg}) - $signed({1'b0, cr});
    assign db = $signed({1'b0, sc_reg}) - $signed({1'b0, cc});
    assign sq_dist = 9'(da * da) + 9'(db * db);

    // steering from the best node
    logic [3:0] br, bc;
    logic signed [5:0] nr, nc;
    logic signed [4:0] dr, dc;
    logic free_c, goal_c;
    logic signed [11:0] gr, gc;
    always_comb
    begin
        br = (best_reg == '0) ? start_row_reg : bestc_reg[7:4];
        bc = (best_reg == '0) ? start_col_reg : bestc_reg[3:0];
        dr = $signed({1'b0, sr_reg}) - $signed({1'b0, br});
        dc = $signed({1'b0, sc_reg}) - $signed({1'b0, bc});
        nr = $signed({2'b0, br});
        nc = $signed({2'b0, bc});
        if (bestd_reg <= 9'd1)
        begin
            nr = $signed({2'b0, sr_reg});
            nc = $signed({2'b0, sc_reg});
        end
        else
        begin
            if (dr < 0) nr = nr - 6'sd1;
            else if (dr > 0 && dc == 0) nr = nr + 6'sd1;
            if (dc < 0) nc = nc - 6'sd1;
            else if (dc > 0 && dr == 0) nc = nc + 6'sd1;
        end
        free_c = 1'b0;
        if (nr >= 0 && 32'(nr) < GRID_ROWS && nc >= 0 && 32'(nc) < GRID_COLS)
            free_c = !grid_reg[nr[3:0]][nc[3:0]];
        // widen so the squared goal distance cannot wrap
        gr = 12'(nr) - 12'($signed({2'b0, goal_row_reg}));
        gc = 12'(nc) - 12'($signed({2'b0, goal_col_reg}));
        goal_c = (gr * gr + gc * gc) <= 12'sd1;
    end

    // sequencer
    logic ld_out;
    logic [2:0] st_o;
    logic [3:0] nr_o, nc_o;
    logic [7:0] ns_o, ps_o;
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        rd_idx = idx_reg;
        bestd_next = bestd_reg;
        best_next = best_reg;
        bestc_next = bestc_reg;
        count_next = count_reg;
        acc_next = acc_reg;
        done_next = done_reg;
        wr_en = 1'b0;
        wr_addr = count_reg[SW-1:0];
        wr_coord = {nr[3:0], nc[3:0]};
        wr_par = 8'(best_reg);
        ld_out = 1'b0;
        st_o = rrt_pkg::ST_LOADED;
        nr_o = '0;
        nc_o = '0;
        ns_o = '0;
        ps_o = '0;
        unique case (state_reg)
            rrt_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_ch.action)
                    begin
                        ld_out = 1'b1;
                        st_o = rrt_pkg::ST_LOADED;
                    end
                    else if (done_reg)
                    begin
                        ld_out = 1'b1;
                        st_o = rrt_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next = '0;
                        rd_idx = '0;
                        bestd_next = 9'h1FF;
                        best_next = '0;
                        state_next = rrt_pkg::S_WAIT;
                    end
                end
            end
            rrt_pkg::S_WAIT:
            begin
                state_next = rrt_pkg::S_SCAN;
            end
            rrt_pkg::S_SCAN:
            begin
                if (bestd_reg == 9'h1FF || sq_dist < bestd_reg)
                begin
                    bestd_next = sq_dist;
                    best_next = cur_idx[SW-1:0];
                    bestc_next = rd_coord_reg;
                end
                if (cur_idx + 1'b1 >= count_reg)
                    state_next = rrt_pkg::S_STEER;
                else
                begin
                    idx_next = cur_idx + 1'b1;
                    rd_idx = idx_next;
                    state_next = rrt_pkg::S_WAIT;
                end
            end
            rrt_pkg::S_STEER:
            begin
                ld_out = 1'b1;
                state_next = rrt_pkg::S_IDLE;
                nr_o = nr[3:0];
                nc_o = nc[3:0];
                ps_o = 8'(best_reg);
                if (!free_c)
                    st_o = rrt_pkg::ST_BLOCKED;
                else if (32'(count_reg) >= NODE_SLOTS)
                begin
                    st_o = rrt_pkg::ST_FULL;
                    done_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    ns_o = 8'(count_reg);
                    count_next = count_reg + 1'b1;
                    if (goal_c)
                    begin
                        st_o = rrt_pkg::ST_GOAL;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        st_o = rrt_pkg::ST_ADDED;
                        if (acc_reg != 16'hFFFF)
                            acc_next = acc_reg + 1'b1;
                        if (acc_next >= limit_reg)
                            done_next = 1'b1;
                    end
                end
            end
            default: state_next = rrt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrt_pkg::S_IDLE;
            count_reg <= CW'(1);
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            bestd_reg <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            bestd_reg <= bestd_next;
            best_reg  <= best_next;
            if (ld_out)
                ov_reg <= 1'b1;
            else if (out_acc)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bestc_reg <= bestc_next;
        if (in_acc)
        begin
            sr_reg <= in_ch.sample_row;
            sc_reg <= in_ch.sample_col;
        end
        if (ld_out)
        begin
            ost_reg  <= st_o;
            onr_reg  <= nr_o;
            onc_reg  <= nc_o;
            ons_reg  <= ns_o;
            ops_reg  <= ps_o;
            ofin_reg <= done_next;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.status      = ost_reg;
    assign out_ch.node_row    = onr_reg;
    assign out_ch.node_col    = onc_reg;
    assign out_ch.node_slot   = ons_reg;
    assign out_ch.parent_slot = ops_reg;
    assign out_ch.finished    = ofin_reg;
endmodule
